[sv/ftfw_pkg.sv]
// Shared types and constants of the five-tuple firewall lookup block.
package ftfw_pkg;

    localparam int KEY_W    = 104;
    localparam int BUCKET_W = 10;
    localparam int CHUNK_W  = 8;

    localparam logic       OP_LOOKUP = 1'b0;
    localparam logic       OP_INSERT = 1'b1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef struct packed {
        logic        operation;
        logic [31:0] ip_dst;
        logic [31:0] ip_src;
        logic [15:0] l4_dst;
        logic [15:0] l4_src;
        logic [7:0]  proto;
        logic        rule_action;
    } t_req;

    typedef struct packed {
        logic                verdict;
        logic                hit;
        logic [BUCKET_W-1:0] bucket;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [63:0] addrs;
        logic [39:0] ports_proto;
        logic        action;
    } t_entry;

endpackage

[sv/five_tuple_firewall_lookup_core.sv]
// Top level of the five-tuple firewall lookup: hash, rule table and verdict.
//
//  channel   | ports                     | handshake
//  ----------+---------------------------+------------------------------------------
//  request   | i_req (t_req)             | taken at an edge with start high, busy low
//  result    | o_rsp (t_rsp)             | valid for one cycle while o_rsp_valid high
//
// A request passes through the modulo unit, ending in the bucket capture, then a
// write (insert) or a read and compare (lookup), all with busy high; the result
// strobe comes in the cycle after that, with busy already low.
// After reset a clearing pass writes every table entry invalid, one per cycle,
// with busy high. The receiver cannot stall: each result is shown for exactly
// one cycle.
module five_tuple_firewall_lookup_core #(
    parameter int TABLE_PRIME = 1021
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  ftfw_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    output ftfw_pkg::t_rsp  o_rsp
);
    import ftfw_pkg::*;

    localparam int IDX_W = $clog2(TABLE_PRIME);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_PRIME - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [IDX_W-1:0] r_clr_idx;
    logic [IDX_W-1:0] r_idx;
    t_req             r_req;
    t_req             key_req;
    logic             r_rsp_valid;
    t_rsp             r_rsp;

    logic             hash_start;
    logic             hash_done;
    logic [IDX_W-1:0] hash_rem;

    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_addr;
    t_entry           ram_wdata;
    t_entry           ram_rdata;
    logic             match;

    // Zero both ports on lookups of protocols other than TCP and UDP.
    always_comb begin
        key_req = i_req;
        if (i_req.operation == OP_LOOKUP &&
            i_req.proto != PROTO_TCP && i_req.proto != PROTO_UDP) begin
            key_req.l4_dst = '0;
            key_req.l4_src = '0;
        end
    end

    assign hash_start = (r_state == ST_IDLE) && start;
    assign busy       = (r_state != ST_IDLE);

    ftfw_mod_unit #(
        .TABLE_PRIME (TABLE_PRIME)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   ({key_req.ip_dst, key_req.ip_src, key_req.l4_dst,
                   key_req.l4_src, key_req.proto}),
        .o_done  (hash_done),
        .o_rem   (hash_rem)
    );

    // Table port: clearing writes, insert writes and lookup reads share it.
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata.valid       = 1'b1;
        ram_wdata.addrs       = {r_req.ip_dst, r_req.ip_src};
        ram_wdata.ports_proto = {r_req.l4_dst, r_req.l4_src, r_req.proto};
        ram_wdata.action      = r_req.rule_action;
        if (r_state == ST_CLEAR) begin
            ram_we          = 1'b1;
            ram_addr        = r_clr_idx;
            ram_wdata.valid = 1'b0;
        end else if (r_state == ST_ACC) begin
            ram_we = (r_req.operation == OP_INSERT);
            ram_re = (r_req.operation == OP_LOOKUP);
        end
    end

    ftfw_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_PRIME)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Full-key compare against the entry read back.
    assign match = ram_rdata.valid &&
                   ram_rdata.addrs == {r_req.ip_dst, r_req.ip_src} &&
                   ram_rdata.ports_proto == {r_req.l4_dst, r_req.l4_src,
                                             r_req.proto};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = (r_req.operation == OP_INSERT) ? ST_IDLE : ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= 1'b0;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            // Raise the result strobe for one cycle when the request retires.
            if ((r_state == ST_ACC && r_req.operation == OP_INSERT) ||
                r_state == ST_CMP) begin
                r_rsp_valid <= 1'b1;
            end
        end
    end

    // Payload: hold the request, the bucket and the result fields.
    always_ff @(posedge i_clk) begin
        if (hash_start) begin
            r_req <= key_req;
        end
        if (r_state == ST_HASH && hash_done) begin
            r_idx <= hash_rem;
        end
        if (r_state == ST_ACC) begin
            r_rsp.verdict <= 1'b1;
            r_rsp.hit     <= 1'b0;
            r_rsp.bucket  <= BUCKET_W'(r_idx);
        end else if (r_state == ST_CMP) begin
            r_rsp.verdict <= match ? ram_rdata.action : 1'b1;
            r_rsp.hit     <= match;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

[sv/ftfw_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module ftfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ftfw_mod_unit.sv]
// Key-modulo-prime unit: weighted byte sum, then a reciprocal-multiply reduction.
module ftfw_mod_unit #(
    parameter int TABLE_PRIME = 1021
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ftfw_pkg::KEY_W-1:0]       i_key,
    output logic                             o_done,
    output logic [$clog2(TABLE_PRIME)-1:0]   o_rem
);
    import ftfw_pkg::*;

    localparam int R_W    = $clog2(TABLE_PRIME);
    localparam int NCHUNK = KEY_W / CHUNK_W;
    localparam int NLO    = (NCHUNK + 1) / 2;
    localparam int SUM_W  = R_W + CHUNK_W + $clog2(NCHUNK);
    localparam int M_W    = SUM_W - R_W + 1;
    localparam int PROD_W = SUM_W + M_W;
    localparam longint unsigned RECIP = (64'd1 << SUM_W) / TABLE_PRIME;
    localparam logic [PROD_W-1:0] RECIP_X = PROD_W'(RECIP);
    localparam logic [R_W:0]      PRIME_X = (R_W+1)'(TABLE_PRIME);

    // Weight of key byte j: 2^(8j) mod prime.
    function automatic longint unsigned chunk_weight(input int j);
        longint unsigned c;
        c = 64'd1;
        for (int k = 0; k < j; k++) begin
            c = (c << CHUNK_W) % TABLE_PRIME;
        end
        return c;
    endfunction

    logic [4:0]        r_vld;
    logic [KEY_W-1:0]  r_key;
    logic [SUM_W-1:0]  r_lo;
    logic [SUM_W-1:0]  r_hi;
    logic [SUM_W-1:0]  r_sum;
    logic [M_W-1:0]    r_q;
    logic [R_W-1:0]    r_rem;
    logic [SUM_W-1:0]  n_lo;
    logic [SUM_W-1:0]  n_hi;
    logic [R_W-1:0]    n_rem;
    logic [SUM_W-1:0]  w_term [NCHUNK];
    logic [PROD_W-1:0] w_prod;
    logic [R_W:0]      w_qp;
    logic [R_W:0]      w_diff;

    // Each byte times its constant weight; the sum is congruent to the key.
    for (genvar g = 0; g < NCHUNK; g++) begin : g_term
        localparam logic [SUM_W-1:0] WEIGHT = SUM_W'(chunk_weight(g));
        assign w_term[g] = SUM_W'(r_key[g*CHUNK_W +: CHUNK_W]) * WEIGHT;
    end

    always_comb begin
        n_lo = '0;
        n_hi = '0;
        for (int k = 0; k < NLO; k++) begin
            n_lo = n_lo + w_term[k];
        end
        for (int k = NLO; k < NCHUNK; k++) begin
            n_hi = n_hi + w_term[k];
        end
    end

    // Quotient estimate is exact or one short, so one subtract finishes.
    assign w_prod = PROD_W'(r_sum) * RECIP_X;
    assign w_qp   = (R_W+1)'(r_q) * PRIME_X;
    assign w_diff = r_sum[R_W:0] - w_qp;

    always_comb begin
        n_rem = w_diff[R_W-1:0];
        if (w_diff >= PRIME_X) begin
            n_rem = R_W'(w_diff - PRIME_X);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_vld[0]) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (r_vld[1]) begin
            r_sum <= r_lo + r_hi;
        end
        if (r_vld[2]) begin
            r_q <= w_prod[SUM_W +: M_W];
        end
        if (r_vld[3]) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_vld[4];
    assign o_rem  = r_rem;

endmodule

[verif/five_tuple_firewall_lookup_core_tb.sv]
// Self-checking testbench for the five-tuple firewall lookup core.
module five_tuple_firewall_lookup_core_tb;

    import ftfw_pkg::*;

    localparam int TABLE_PRIME  = 1021;
    // Reset clearing pass, the longest sender gap and the request latency,
    // taken several times over.
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_REQS  = 630;
    localparam int DRAIN_CYCLES = 40;
    localparam int KEY_POOL_MAX = 48;
    localparam int DIR_ROWS     = 24;

    localparam logic ACT_DROP = 1'b0;
    localparam logic ACT_PASS = 1'b1;

    // One row of the directed table; fixed_rsp is used only where has_fixed is set.
    typedef struct packed {
        t_req req;
        logic has_fixed;
        t_rsp fixed_rsp;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // Shadow rule table, the verdicts still in flight, and keys worth looking up again.
    bit          rule_valid       [TABLE_PRIME];
    logic [63:0] rule_addrs       [TABLE_PRIME];
    logic [39:0] rule_ports_proto [TABLE_PRIME];
    logic        rule_act         [TABLE_PRIME];
    t_rsp        pending_verdicts [$];
    t_req        rule_keys        [$];
    t_stim_row   dir_rows         [DIR_ROWS];

    int mismatches   = 0;
    int quiet_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    five_tuple_firewall_lookup_core #(
        .TABLE_PRIME (TABLE_PRIME)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Apply one request to the shadow table and return the verdict it earns.
    function automatic t_rsp apply_request(input t_req r);
        t_rsp              res;
        longint unsigned   rem;
        logic [9:0]        idx;
        logic [63:0]       addrs;
        logic [39:0]       ports_proto;
        // Lookups ignore ports unless the protocol carries them.
        if (r.operation == OP_LOOKUP && r.proto != PROTO_TCP && r.proto != PROTO_UDP) begin
            r.l4_dst = '0;
            r.l4_src = '0;
        end
        // Fold the 104-bit key field by field, keeping the remainder small.
        rem = 64'(r.ip_dst) % 64'(TABLE_PRIME);
        rem = ((rem << 32) + 64'(r.ip_src)) % 64'(TABLE_PRIME);
        rem = ((rem << 16) + 64'(r.l4_dst)) % 64'(TABLE_PRIME);
        rem = ((rem << 16) + 64'(r.l4_src)) % 64'(TABLE_PRIME);
        rem = ((rem << 8) + 64'(r.proto)) % 64'(TABLE_PRIME);
        idx = 10'(rem);
        addrs       = {r.ip_dst, r.ip_src};
        ports_proto = {r.l4_dst, r.l4_src, r.proto};
        res.verdict = ACT_PASS;
        res.hit     = 1'b0;
        res.bucket  = idx;
        if (r.operation == OP_INSERT) begin
            // Last rule into a bucket wins.
            rule_valid[idx]       = 1'b1;
            rule_addrs[idx]       = addrs;
            rule_ports_proto[idx] = ports_proto;
            rule_act[idx]         = r.rule_action;
        end else if (rule_valid[idx] && rule_addrs[idx] == addrs &&
                     rule_ports_proto[idx] == ports_proto) begin
            res.hit     = 1'b1;
            res.verdict = rule_act[idx];
        end
        return res;
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(9, 0))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(9, 0))
            0: return '0;
            1: return '1;
            default: return 16'($urandom());
        endcase
    endfunction

    // Random key, biased toward TCP and UDP; other protocols often carry zero
    // ports so their rules can still be hit.
    function automatic t_req random_key();
        t_req        k;
        int unsigned pick;
        k.operation = OP_LOOKUP;
        k.ip_dst    = pick32();
        k.ip_src    = pick32();
        k.l4_dst    = pick16();
        k.l4_src    = pick16();
        pick = $urandom_range(99, 0);
        if (pick < 40) begin
            k.proto = PROTO_TCP;
        end else if (pick < 70) begin
            k.proto = PROTO_UDP;
        end else begin
            k.proto = 8'($urandom_range(255, 0));
        end
        if (k.proto != PROTO_TCP && k.proto != PROTO_UDP && $urandom_range(1, 0) == 1) begin
            k.l4_dst = '0;
            k.l4_src = '0;
        end
        k.rule_action = 1'($urandom_range(1, 0));
        return k;
    endfunction

    // Idle for a random gap, present the request, hold it until accepted,
    // then queue its expected verdict. Returns on the accepting edge.
    task automatic issue_request(input t_req r, input logic has_fixed, input t_rsp fixed_rsp);
        int unsigned  pick;
        int unsigned  gap;
        logic [127:0] noise;
        t_rsp         predicted;
        pick = $urandom_range(99, 0);
        if (pick < 50) begin
            gap = 0;
        end else if (pick < 75) begin
            gap = $urandom_range(3, 1);
        end else if (pick < 92) begin
            gap = $urandom_range(35, 4);
        end else begin
            gap = $urandom_range(80, 36);
        end
        if (gap != 0) begin
            start <= 1'b0;
        end
        // Drive garbage on the payload while start is low; it must be ignored.
        repeat (gap) begin
            noise = {$urandom(), $urandom(), $urandom(), $urandom()};
            i_req <= noise[$bits(t_req)-1:0];
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        predicted = apply_request(r);
        pending_verdicts.push_back(has_fixed ? fixed_rsp : predicted);
    endtask

    // Result checker and watchdog: compare each strobed result with the oldest
    // expectation; end the run if nothing moves for too long.
    always @(posedge i_clk) begin : watch_results
        t_rsp want;
        if (i_rst_n) begin
            if ((start && busy === 1'b0) || o_rsp_valid === 1'b1) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end else if (o_rsp_valid === 1'b1) begin
                if (pending_verdicts.size() == 0) begin
                    flag_mismatch($sformatf("result with no request pending, bucket %0d",
                                            o_rsp.bucket));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_rsp.verdict !== want.verdict) begin
                        flag_mismatch($sformatf("verdict %b, want %b (bucket %0d)",
                                                o_rsp.verdict, want.verdict, want.bucket));
                    end
                    if (o_rsp.hit !== want.hit) begin
                        flag_mismatch($sformatf("hit %b, want %b (bucket %0d)",
                                                o_rsp.hit, want.hit, want.bucket));
                    end
                    if (o_rsp.bucket !== want.bucket) begin
                        flag_mismatch($sformatf("bucket %0d, want %0d",
                                                o_rsp.bucket, want.bucket));
                    end
                end
            end
        end
    end

    initial begin
        t_req        r;
        int unsigned sel;
        int unsigned sub;

        // Directed requests. Typed verdicts only for the all-zero key, whose
        // bucket is zero; everything else goes through the predictor.
        dir_rows = '{
            // empty table: a lookup misses and passes
            '{'{OP_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 8'd0, ACT_DROP},
              1'b1, '{ACT_PASS, 1'b0, 10'd0}},
            // insert a drop rule on the all-zero key
            '{'{OP_INSERT, 32'h0, 32'h0, 16'h0, 16'h0, 8'd0, ACT_DROP},
              1'b1, '{ACT_PASS, 1'b0, 10'd0}},
            // lookup ignores its own action field
            '{'{OP_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 8'd0, ACT_PASS},
              1'b1, '{ACT_DROP, 1'b1, 10'd0}},
            // non-TCP/UDP lookup: ports dropped before hashing, so still a hit
            '{'{OP_LOOKUP, 32'h0, 32'h0, 16'hFFFF, 16'h1234, 8'd0, ACT_PASS},
              1'b1, '{ACT_DROP, 1'b1, 10'd0}},
            // all-ones key: rule stored with ports, lookup loses them
            '{'{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, ACT_PASS},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, ACT_PASS},
              1'b0, '0},
            '{'{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 16'h0, 8'hFF, ACT_DROP},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, ACT_PASS},
              1'b0, '0},
            // TCP rule: exact hit, then a one-port miss
            '{'{OP_INSERT, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd1234, PROTO_TCP, ACT_DROP},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd1234, PROTO_TCP, ACT_PASS},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'hC0A8_0001, 32'h0A00_0001, 16'd81, 16'd1234, PROTO_TCP, ACT_DROP},
              1'b0, '0},
            // UDP rule with extreme ports
            '{'{OP_INSERT, 32'h0808_0808, 32'hC0A8_0164, 16'd53, 16'hFFFF, PROTO_UDP, ACT_PASS},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'h0808_0808, 32'hC0A8_0164, 16'd53, 16'hFFFF, PROTO_UDP, ACT_DROP},
              1'b0, '0},
            // ICMP rule with nonzero ports can never match
            '{'{OP_INSERT, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd7, 16'd9, 8'd1, ACT_DROP},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd7, 16'd9, 8'd1, ACT_DROP},
              1'b0, '0},
            // overwrite the TCP rule with a pass
            '{'{OP_INSERT, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd1234, PROTO_TCP, ACT_PASS},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd1234, PROTO_TCP, ACT_DROP},
              1'b0, '0},
            // source offset by the table size lands in the same bucket and evicts
            '{'{OP_INSERT, 32'hC0A8_0001, 32'h0A00_03FE, 16'd80, 16'd1234, PROTO_TCP, ACT_DROP},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd1234, PROTO_TCP, ACT_DROP},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'hC0A8_0001, 32'h0A00_03FE, 16'd80, 16'd1234, PROTO_TCP, ACT_PASS},
              1'b0, '0},
            // mixed extremes
            '{'{OP_LOOKUP, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, PROTO_UDP, ACT_PASS},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'hFFFF, PROTO_TCP, ACT_DROP},
              1'b0, '0},
            '{'{OP_INSERT, 32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001, 8'h80, ACT_PASS},
              1'b0, '0},
            '{'{OP_LOOKUP, 32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001, 8'h80, ACT_DROP},
              1'b0, '0}
        };

        // Hold reset, release it, then let the clearing pass raise busy.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (dir_rows[i]) begin
            issue_request(dir_rows[i].req, dir_rows[i].has_fixed, dir_rows[i].fixed_rsp);
        end

        // Random traffic: about a third inserts, the rest lookups that mostly
        // revisit recent rules, some with one bit flipped, some fresh keys.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            sel = $urandom_range(99, 0);
            sub = $urandom_range(99, 0);
            if (sel < 35) begin
                if (rule_keys.size() == 0 || sub < 60) begin
                    r = random_key();
                end else begin
                    r = rule_keys[$urandom_range(rule_keys.size() - 1, 0)];
                    // Offset the source by the table size to force a bucket collision.
                    if (sub < 85) begin
                        r.ip_src = r.ip_src + 32'(TABLE_PRIME);
                    end
                end
                r.operation   = OP_INSERT;
                r.rule_action = 1'($urandom_range(1, 0));
                rule_keys.push_back(r);
                if (rule_keys.size() > KEY_POOL_MAX) begin
                    void'(rule_keys.pop_front());
                end
            end else begin
                if (rule_keys.size() != 0 && sub < 80) begin
                    r = rule_keys[$urandom_range(rule_keys.size() - 1, 0)];
                    if (sub >= 60) begin
                        case ($urandom_range(4, 0))
                            0: r.ip_dst ^= 32'(1) << $urandom_range(31, 0);
                            1: r.ip_src ^= 32'(1) << $urandom_range(31, 0);
                            2: r.l4_dst ^= 16'(1) << $urandom_range(15, 0);
                            3: r.l4_src ^= 16'(1) << $urandom_range(15, 0);
                            default: r.proto ^= 8'(1) << $urandom_range(7, 0);
                        endcase
                    end
                end else begin
                    r = random_key();
                end
                r.operation   = OP_LOOKUP;
                r.rule_action = 1'($urandom_range(1, 0));
            end
            issue_request(r, 1'b0, '0);
        end

        // Drop start, drain outstanding results, then watch for strays.
        start <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[five_tuple_firewall_lookup_core.f]
sv/ftfw_pkg.sv
sv/ftfw_ram.sv
sv/ftfw_mod_unit.sv
sv/five_tuple_firewall_lookup_core.sv
verif/five_tuple_firewall_lookup_core_tb.sv
